@@ rtl/wvs_pkg.sv @@
// Shared types, widths and the per-step operation table of the skinning core.
// No dependencies.
package wvs_pkg;

  // Operand widths of the shared multiplier and its products
  localparam int unsigned OpaW  = 43;   // offset, cross term or biased position
  localparam int unsigned OpbW  = 18;   // quaternion component or bias
  localparam int unsigned ProdW = OpaW + OpbW;
  localparam int unsigned AccW  = 55;   // cross product / rotation partial sums
  localparam int unsigned SumW  = 56;   // vertex accumulators
  localparam int unsigned StepW = 5;
  localparam int unsigned NumOps = 18;  // multiplies per weight
  localparam logic [StepW-1:0] LastStep = StepW'(NumOps);

  // Stream payload widths
  localparam int unsigned InDataW  = 280;
  localparam int unsigned OutDataW = 96;

  // Operand A selectors
  localparam logic [3:0] ASelV0 = 4'd0;
  localparam logic [3:0] ASelV1 = 4'd1;
  localparam logic [3:0] ASelV2 = 4'd2;
  localparam logic [3:0] ASelT0 = 4'd3;
  localparam logic [3:0] ASelT1 = 4'd4;
  localparam logic [3:0] ASelT2 = 4'd5;
  localparam logic [3:0] ASelP0 = 4'd6;
  localparam logic [3:0] ASelP1 = 4'd7;
  localparam logic [3:0] ASelP2 = 4'd8;

  // Operand B selectors
  localparam logic [2:0] BSelUx   = 3'd0;
  localparam logic [2:0] BSelUy   = 3'd1;
  localparam logic [2:0] BSelUz   = 3'd2;
  localparam logic [2:0] BSelW    = 3'd3;
  localparam logic [2:0] BSelBias = 3'd4;

  // What happens to a product once it lands
  typedef enum logic [1:0] {
    FIN_NONE = 2'd0,   // partial sum only
    FIN_T    = 2'd1,   // close t = 2(u x v)
    FIN_R    = 2'd2,   // close rotated, translated position
    FIN_S    = 2'd3    // scale by bias into the vertex sum
  } fin_t;

  typedef struct packed {
    logic [3:0] a_sel;
    logic [2:0] b_sel;
    logic       neg;
    logic       first;
    fin_t       fin;
    logic [1:0] k;
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

  function automatic op_t mk(input logic [3:0] a, input logic [2:0] b, input logic n,
                             input logic f, input fin_t fn, input logic [1:0] k);
    op_t o;
    o.a_sel = a; o.b_sel = b; o.neg = n; o.first = f; o.fin = fn; o.k = k;
    return o;
  endfunction

  // Schedule: six multiplies for t, nine for the rotation, three for the bias
  function automatic op_t step_op(input logic [StepW-1:0] idx);
    op_t o;
    o = mk(ASelV0, BSelUx, 1'b0, 1'b1, FIN_NONE, 2'd0);
    case (idx)
      5'd0:  o = mk(ASelV2, BSelUy, 1'b0, 1'b1, FIN_NONE, 2'd0);
      5'd1:  o = mk(ASelV1, BSelUz, 1'b1, 1'b0, FIN_T,    2'd0);
      5'd2:  o = mk(ASelV0, BSelUz, 1'b0, 1'b1, FIN_NONE, 2'd1);
      5'd3:  o = mk(ASelV2, BSelUx, 1'b1, 1'b0, FIN_T,    2'd1);
      5'd4:  o = mk(ASelV1, BSelUx, 1'b0, 1'b1, FIN_NONE, 2'd2);
      5'd5:  o = mk(ASelV0, BSelUy, 1'b1, 1'b0, FIN_T,    2'd2);
      5'd6:  o = mk(ASelT0, BSelW,  1'b0, 1'b1, FIN_NONE, 2'd0);
      5'd7:  o = mk(ASelT2, BSelUy, 1'b0, 1'b0, FIN_NONE, 2'd0);
      5'd8:  o = mk(ASelT1, BSelUz, 1'b1, 1'b0, FIN_R,    2'd0);
      5'd9:  o = mk(ASelT1, BSelW,  1'b0, 1'b1, FIN_NONE, 2'd1);
      5'd10: o = mk(ASelT0, BSelUz, 1'b0, 1'b0, FIN_NONE, 2'd1);
      5'd11: o = mk(ASelT2, BSelUx, 1'b1, 1'b0, FIN_R,    2'd1);
      5'd12: o = mk(ASelT2, BSelW,  1'b0, 1'b1, FIN_NONE, 2'd2);
      5'd13: o = mk(ASelT1, BSelUx, 1'b0, 1'b0, FIN_NONE, 2'd2);
      5'd14: o = mk(ASelT0, BSelUy, 1'b1, 1'b0, FIN_R,    2'd2);
      5'd15: o = mk(ASelP0, BSelBias, 1'b0, 1'b1, FIN_S,  2'd0);
      5'd16: o = mk(ASelP1, BSelBias, 1'b0, 1'b1, FIN_S,  2'd1);
      5'd17: o = mk(ASelP2, BSelBias, 1'b0, 1'b1, FIN_S,  2'd2);
      default: o = mk(ASelV0, BSelUx, 1'b0, 1'b1, FIN_NONE, 2'd0);
    endcase
    return o;
  endfunction

endpackage

@@ rtl/wvs_mult.sv @@
// Shared signed multiplier with a registered product.
// Depends on wvs_pkg for operand widths.
module wvs_mult (
  input  logic                                   clk,
  input  logic signed [wvs_pkg::OpaW-1:0]        a,
  input  logic signed [wvs_pkg::OpbW-1:0]        b,
  output logic signed [wvs_pkg::ProdW-1:0]       prod
);

  // One product per cycle, registered before any use
  always_ff @(posedge clk) begin
    prod <= wvs_pkg::ProdW'(a) * wvs_pkg::ProdW'(b);
  end

endmodule

@@ rtl/weighted_vertex_skinning_core.sv @@
// Weighted vertex skinning core: quaternion rotation, translation and bias
// scaling of one weight per beat, through one shared multiplier.
// A new weight is taken only in the idle state, so each weight finishes before the next
// beat: 18 multiplies on the shared unit, then the drain of its product register, then
// the idle state to take the next beat; a last weight adds an emit state, held while the
// previous vertex is unread, and m_tvalid is registered from that state.
// Reset (rst, synchronous) clears the sequencer, output valid and vertex sums.
module weighted_vertex_skinning_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // rot_x, rot_y, rot_z, rot_w, joint_pos_x/y/z, offset_x/y/z, bias, zero pad
  input  logic [wvs_pkg::InDataW-1:0]       s_tdata,
  input  logic                              s_tlast,   // last_weight
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // vertex_x, vertex_y, vertex_z
  output logic [wvs_pkg::OutDataW-1:0]      m_tdata
);

  localparam int unsigned AW = wvs_pkg::OpaW;

  wvs_pkg::state_t state, state_next;
  logic [wvs_pkg::StepW-1:0] step;
  logic last_q;

  // Latched beat
  logic signed [15:0] ux, uy, uz, uw;
  logic signed [31:0] v0, v1, v2, jp0, jp1, jp2;
  logic [16:0] bias;

  // Intermediates
  logic signed [AW-1:0] t0, t1, t2, p0, p1, p2;
  logic signed [wvs_pkg::AccW-1:0] acc;
  logic signed [wvs_pkg::SumW-1:0] sum0, sum1, sum2;
  logic [31:0] out0, out1, out2;

  logic in_beat, out_beat, last_acc;
  wvs_pkg::op_t iss, aop;
  logic signed [AW-1:0] opa;
  logic signed [wvs_pkg::OpbW-1:0] opb;
  logic signed [wvs_pkg::ProdW-1:0] prod;

  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;
  assign last_acc = (state == wvs_pkg::ST_RUN) && (step == wvs_pkg::LastStep);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      wvs_pkg::ST_IDLE: if (in_beat) state_next = wvs_pkg::ST_RUN;
      wvs_pkg::ST_RUN:  if (last_acc) state_next = last_q ? wvs_pkg::ST_EMIT
                                                            : wvs_pkg::ST_IDLE;
      wvs_pkg::ST_EMIT: if (!m_tvalid || m_tready) state_next = wvs_pkg::ST_IDLE;
      default:          state_next = wvs_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_tready = (state == wvs_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wvs_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (in_beat) step <= '0;
      else if (state == wvs_pkg::ST_RUN) step <= step + 1'b1;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_beat) begin
      ux  <= s_tdata[15:0];    uy  <= s_tdata[31:16];
      uz  <= s_tdata[47:32];   uw  <= s_tdata[63:48];
      jp0 <= s_tdata[95:64];   jp1 <= s_tdata[127:96];  jp2 <= s_tdata[159:128];
      v0  <= s_tdata[191:160]; v1  <= s_tdata[223:192]; v2  <= s_tdata[255:224];
      bias   <= s_tdata[272:256];
      last_q <= s_tlast;
    end
  end

  // Issue side: operand selection for the current step
  assign iss = wvs_pkg::step_op(step);

  always_comb begin
    case (iss.a_sel)
      wvs_pkg::ASelV0: opa = AW'(v0);
      wvs_pkg::ASelV1: opa = AW'(v1);
      wvs_pkg::ASelV2: opa = AW'(v2);
      wvs_pkg::ASelT0: opa = t0;
      wvs_pkg::ASelT1: opa = t1;
      wvs_pkg::ASelT2: opa = t2;
      wvs_pkg::ASelP0: opa = p0;
      wvs_pkg::ASelP1: opa = p1;
      wvs_pkg::ASelP2: opa = p2;
      default:         opa = '0;
    endcase
    case (iss.b_sel)
      wvs_pkg::BSelUx:   opb = wvs_pkg::OpbW'(ux);
      wvs_pkg::BSelUy:   opb = wvs_pkg::OpbW'(uy);
      wvs_pkg::BSelUz:   opb = wvs_pkg::OpbW'(uz);
      wvs_pkg::BSelW:    opb = wvs_pkg::OpbW'(uw);
      wvs_pkg::BSelBias: opb = {1'b0, bias};
      default:           opb = '0;
    endcase
  end

  wvs_mult u_mult (.clk(clk), .a(opa), .b(opb), .prod(prod));

  // Accumulate side: the product issued one step earlier
  logic signed [wvs_pkg::AccW-1:0] acc_in, acc_new, prod_s;
  logic signed [wvs_pkg::AccW:0]   acc_rnd;
  logic signed [AW-1:0] t_new, r_rnd, vk, jk, p_new;
  logic signed [wvs_pkg::ProdW:0] s_rnd;
  logic signed [AW+1:0] s_val;
  logic signed [wvs_pkg::SumW-1:0] sum_k;
  logic signed [wvs_pkg::SumW:0] sum_wide;
  logic signed [wvs_pkg::SumW-1:0] sum_sat;
  logic acc_en;

  assign aop    = wvs_pkg::step_op(step - 1'b1);
  assign acc_en = (state == wvs_pkg::ST_RUN) && (step != '0);

  always_comb begin
    prod_s  = prod[wvs_pkg::AccW-1:0];
    acc_in  = aop.first ? '0 : acc;
    acc_new = aop.neg ? acc_in - prod_s : acc_in + prod_s;
    // t = round(2c / 2^14) = floor((c + 2^12) / 2^13)
    acc_rnd = {acc_new[wvs_pkg::AccW-1], acc_new} + (wvs_pkg::AccW+1)'(1 << 12);
    t_new   = AW'(acc_rnd >>> 13);
    // rotated term rounded by 2^14
    acc_rnd = {acc_new[wvs_pkg::AccW-1], acc_new} + (wvs_pkg::AccW+1)'(1 << 13);
    r_rnd   = AW'(acc_rnd >>> 14);
    case (aop.k)
      2'd0:    begin vk = AW'(v0); jk = AW'(jp0); sum_k = sum0; end
      2'd1:    begin vk = AW'(v1); jk = AW'(jp1); sum_k = sum1; end
      default: begin vk = AW'(v2); jk = AW'(jp2); sum_k = sum2; end
    endcase
    p_new = vk + r_rnd + jk;
    // bias scaling, rounded by 2^16, then saturating add
    s_rnd    = {prod[wvs_pkg::ProdW-1], prod} + (wvs_pkg::ProdW+1)'(1 << 15);
    s_val    = (AW+2)'(s_rnd >>> 16);
    sum_wide = {sum_k[wvs_pkg::SumW-1], sum_k} + (wvs_pkg::SumW+1)'(s_val);
    if (sum_wide[wvs_pkg::SumW] != sum_wide[wvs_pkg::SumW-1])
      sum_sat = sum_wide[wvs_pkg::SumW] ? {1'b1, {(wvs_pkg::SumW-1){1'b0}}}
                                        : {1'b0, {(wvs_pkg::SumW-1){1'b1}}};
    else
      sum_sat = sum_wide[wvs_pkg::SumW-1:0];
  end

  // Partial sums, t and p registers
  always_ff @(posedge clk) begin
    if (acc_en) begin
      acc <= acc_new;
      if (aop.fin == wvs_pkg::FIN_T) begin
        case (aop.k)
          2'd0:    t0 <= t_new;
          2'd1:    t1 <= t_new;
          default: t2 <= t_new;
        endcase
      end
      if (aop.fin == wvs_pkg::FIN_R) begin
        case (aop.k)
          2'd0:    p0 <= p_new;
          2'd1:    p1 <= p_new;
          default: p2 <= p_new;
        endcase
      end
    end
  end

  // Output clamp to 32 bits
  function automatic logic [31:0] clamp32(input logic signed [wvs_pkg::SumW-1:0] x);
    logic [31:0] r;
    if (x[wvs_pkg::SumW-1:31] == '0 || x[wvs_pkg::SumW-1:31] == '1)
      r = x[31:0];
    else
      r = x[wvs_pkg::SumW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return r;
  endfunction

  logic emit_go;
  assign emit_go = (state == wvs_pkg::ST_EMIT) && (!m_tvalid || m_tready);

  // Vertex sums: scaled adds, cleared on reset and when the vertex is emitted
  always_ff @(posedge clk) begin
    if (rst || emit_go) begin
      sum0 <= '0; sum1 <= '0; sum2 <= '0;
    end else if (acc_en && aop.fin == wvs_pkg::FIN_S) begin
      case (aop.k)
        2'd0:    sum0 <= sum_sat;
        2'd1:    sum1 <= sum_sat;
        default: sum2 <= sum_sat;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (emit_go) m_tvalid <= 1'b1;
    else if (out_beat) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out0 <= clamp32(sum0);
      out1 <= clamp32(sum1);
      out2 <= clamp32(sum2);
    end
  end

  assign m_tdata = {out2, out1, out0};

endmodule

@@ tb/tb_weighted_vertex_skinning_core.sv @@
// Self-checking bench for weighted_vertex_skinning_core: directed table, then random vertices.
// Skinned positions come from an in-bench fixed-point rotate/translate/bias model.
// Depends on rtl/wvs_pkg.sv and rtl/weighted_vertex_skinning_core.sv.
module tb_weighted_vertex_skinning_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [15:0] rx, ry, rz, rw;
    logic signed [31:0] jx, jy, jz;
    logic signed [31:0] ox, oy, oz;
    logic [16:0]        bias;
    logic               last;
    bit                 has_vtx;   // vertex typed into the table
    logic signed [31:0] vx, vy, vz;
  } weight_t;

  typedef struct {
    logic signed [31:0] x, y, z;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [wvs_pkg::InDataW-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [wvs_pkg::OutDataW-1:0] m_tdata;

  weighted_vertex_skinning_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Model state and scoreboard
  wide_t   blend_sum [3];
  vertex_t vertex_q[$];
  weight_t sent_q[$];      // beat being offered, pairs typed rows with acceptance
  int      err_cnt = 0;
  int      snd_idle = 0;
  int      rcv_idle = 0;
  int      hold_cnt = 0;
  longint  cycle_cnt = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic wide_t rnd_shift(input wide_t x, input int n);
    return (x + (wide_t'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic wide_t clip(input wide_t x, input int w);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // Rotate, translate and scale one weight into the vertex sums; on last, emit
  function automatic void skin_weight(input weight_t wt);
    wide_t ux, uy, uz, qw, bs;
    wide_t v[3], jp[3], t[3], r[3];
    vertex_t vo;
    ux = wt.rx; uy = wt.ry; uz = wt.rz; qw = wt.rw;
    bs = {111'b0, wt.bias};
    v[0] = wt.ox; v[1] = wt.oy; v[2] = wt.oz;
    jp[0] = wt.jx; jp[1] = wt.jy; jp[2] = wt.jz;
    t[0] = rnd_shift(2 * (uy * v[2] - uz * v[1]), 14);
    t[1] = rnd_shift(2 * (uz * v[0] - ux * v[2]), 14);
    t[2] = rnd_shift(2 * (ux * v[1] - uy * v[0]), 14);
    r[0] = v[0] + rnd_shift(qw * t[0] + (uy * t[2] - uz * t[1]), 14);
    r[1] = v[1] + rnd_shift(qw * t[1] + (uz * t[0] - ux * t[2]), 14);
    r[2] = v[2] + rnd_shift(qw * t[2] + (ux * t[1] - uy * t[0]), 14);
    for (int i = 0; i < 3; i++)
      blend_sum[i] = clip(blend_sum[i] + rnd_shift((r[i] + jp[i]) * bs, 16),
                          wvs_pkg::SumW);
    if (wt.last) begin
      vo.x = clip(blend_sum[0], 32);
      vo.y = clip(blend_sum[1], 32);
      vo.z = clip(blend_sum[2], 32);
      if (wt.has_vtx) begin
        vo.x = wt.vx; vo.y = wt.vy; vo.z = wt.vz;
      end
      vertex_q = {vertex_q, vo};
      for (int i = 0; i < 3; i++) blend_sum[i] = '0;
    end
  endfunction

  // Input beats: feed the model
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) skin_weight(sent_q.pop_front());
  end

  // Output beats: compare with oldest vertex
  always @(posedge clk) begin
    vertex_t ev;
    if (!rst && m_tvalid && m_tready) begin
      if (vertex_q.size() == 0) begin
        $error("unexpected vertex beat %h", m_tdata);
        err_cnt++;
      end else begin
        ev = vertex_q.pop_front();
        if (m_tdata[31:0] !== ev.x) begin
          $error("vertex_x expected %h got %h", ev.x, m_tdata[31:0]);
          err_cnt++;
        end
        if (m_tdata[63:32] !== ev.y) begin
          $error("vertex_y expected %h got %h", ev.y, m_tdata[63:32]);
          err_cnt++;
        end
        if (m_tdata[95:64] !== ev.z) begin
          $error("vertex_z expected %h got %h", ev.z, m_tdata[95:64]);
          err_cnt++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 1000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one weight beat, called at a falling edge
  task automatic send_weight(input weight_t wt);
    while ($urandom_range(0, 99) < snd_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    sent_q = {wt};
    s_tvalid <= 1'b1;
    s_tlast  <= wt.last;
    s_tdata  <= {7'b0, wt.bias, wt.oz, wt.oy, wt.ox, wt.jz, wt.jy, wt.jx,
                 wt.rw, wt.rz, wt.ry, wt.rx};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  function automatic weight_t mk_row(input int rx, ry, rz, rw, input int jx, jy, jz,
                                     input int ox, oy, oz, input int bias, input bit last);
    weight_t wt;
    wt.rx = 16'(rx); wt.ry = 16'(ry); wt.rz = 16'(rz); wt.rw = 16'(rw);
    wt.jx = jx; wt.jy = jy; wt.jz = jz;
    wt.ox = ox; wt.oy = oy; wt.oz = oz;
    wt.bias = 17'(bias); wt.last = last;
    wt.has_vtx = 0; wt.vx = 0; wt.vy = 0; wt.vz = 0;
    return wt;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return $signed($urandom_range(0, 1310720)) - 655360;   // within +-10.0
  endfunction

  // Random weight: mostly rotations of sensible size, some arbitrary quaternions
  function automatic weight_t rand_weight(input bit last);
    weight_t wt;
    int ax;
    wt = mk_row(0, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0, last);
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        ax = $urandom_range(0, 2);
        wt.rw = 16'(11585);
        if (ax == 0) wt.rx = 16'($urandom_range(0, 1) ? 11585 : -11585);
        if (ax == 1) wt.ry = 16'($urandom_range(0, 1) ? 11585 : -11585);
        if (ax == 2) wt.rz = 16'($urandom_range(0, 1) ? 11585 : -11585);
      end
      2: begin
        wt.rx = 16'($signed($urandom_range(0, 16384)) - 8192);
        wt.ry = 16'($signed($urandom_range(0, 16384)) - 8192);
        wt.rz = 16'($signed($urandom_range(0, 16384)) - 8192);
        wt.rw = 16'($signed($urandom_range(0, 16384)) - 8192);
      end
      default: begin
        wt.rx = 16'($urandom()); wt.ry = 16'($urandom());
        wt.rz = 16'($urandom()); wt.rw = 16'($urandom());
      end
    endcase
    wt.jx = rand_coord(); wt.jy = rand_coord(); wt.jz = rand_coord();
    wt.ox = rand_coord(); wt.oy = rand_coord(); wt.oz = rand_coord();
    wt.bias = ($urandom_range(0, 7) == 0) ? 17'($urandom_range(0, 131071))
                                          : 17'($urandom_range(0, 65536));
    return wt;
  endfunction

  weight_t dir_tab[$];

  initial begin
    weight_t wt;
    int nw, sent;
    for (int i = 0; i < 3; i++) blend_sum[i] = '0;

    // Directed rows; typed vertices only where they follow at a glance
    wt = mk_row(0, 0, 0, 16384, 32'h10000, -32'h10000, 0, 0, 0, 0, 65536, 1);
    wt.has_vtx = 1; wt.vx = 32'h10000; wt.vy = -32'h10000; wt.vz = 0;
    dir_tab = {dir_tab, wt};
    wt = mk_row(0, 0, 0, 16384, 0, 0, 0, 32'h20000, 0, 0, 32768, 1);
    wt.has_vtx = 1; wt.vx = 32'h10000; wt.vy = 0; wt.vz = 0;
    dir_tab = {dir_tab, wt};
    wt = mk_row(0, 0, 0, 16384, 32'h12345, 7, -9, 32'h777, 3, 3, 0, 1);
    wt.has_vtx = 1; wt.vx = 0; wt.vy = 0; wt.vz = 0;
    dir_tab = {dir_tab, wt};
    // positive and negative output saturation, bias above one
    wt = mk_row(0, 0, 0, 16384, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 131071, 1);
    wt.has_vtx = 1; wt.vx = 32'h7fffffff; wt.vy = 32'h7fffffff; wt.vz = 32'h7fffffff;
    dir_tab = {dir_tab, wt};
    wt = mk_row(0, 0, 0, 16384, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000, 32'h80000000, 32'h80000000, 131071, 1);
    wt.has_vtx = 1; wt.vx = 32'h80000000; wt.vy = 32'h80000000; wt.vz = 32'h80000000;
    dir_tab = {dir_tab, wt};
    // quarter turns and non-unit quaternions, model-checked
    dir_tab = {dir_tab, mk_row(0, 0, 11585, 11585, 0, 0, 0, 32'h10000, 0, 0, 65536, 1)};
    dir_tab = {dir_tab, mk_row(11585, 0, 0, -11585, 5, 6, 7, 0, 32'h30000, 0, 65536, 1)};
    dir_tab = {dir_tab, mk_row(-32768, -32768, -32768, -32768, 32'h7fffffff, 0, 0,
                               32'h7fffffff, 32'h80000000, 32'h7fffffff, 131071, 0)};
    dir_tab = {dir_tab, mk_row(32767, 32767, 32767, 32767, 32'h80000000, 0, 32'h7fffffff,
                               32'h80000000, 32'h7fffffff, 32'h80000000, 65537, 1)};
    dir_tab = {dir_tab, mk_row(32767, -32768, 0, 0, 1, -1, 1, -1, 1, -1, 1, 1)};
    // a four-weight vertex
    dir_tab = {dir_tab, mk_row(0, 11585, 0, 11585, 32'h10000, 0, 0, 32'h8000, 0, 0,
                               16384, 0)};
    dir_tab = {dir_tab, mk_row(0, 0, 0, 16384, 0, 32'h10000, 0, 0, 32'h8000, 0, 16384, 0)};
    dir_tab = {dir_tab, mk_row(8192, 8192, 8192, 8192, 0, 0, 32'h10000, 0, 0, 32'h8000,
                               16384, 0)};
    dir_tab = {dir_tab, mk_row(0, 0, 0, -16384, 32'h20000, 32'h20000, 32'h20000,
                               32'h1000, 32'h1000, 32'h1000, 16384, 1)};

    // Reset
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) send_weight(dir_tab[i]);

    // Random vertices over three idling regimes
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 21 : (ph == 1) ? 68 : 0;
      rcv_idle = (ph == 0) ? 68 : (ph == 1) ? 21 : 0;
      if (ph == 2) hold_cnt = 300;   // block fills while the sender keeps offering
      sent = 0;
      while (sent < 230) begin
        nw = $urandom_range(1, 5);
        for (int k = 0; k < nw; k++) send_weight(rand_weight(k == nw - 1));
        sent += nw;
        if (ph == 1 && sent >= 115 && sent < 115 + nw) begin
          s_tvalid <= 1'b0;
          wait (vertex_q.size() == 0);
          @(negedge clk);
        end
      end
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    // Drain
    wait (vertex_q.size() == 0);
    repeat (60) @(posedge clk);
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
